### rtl/lzwbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwbc_pkg
// Shared constants and types of the LZW byte compressor.
// ----------------------------------------------------------------------------
package lzwbc_pkg;

    localparam int DICT_ENTRIES_DEF = 4096;
    localparam int HASH_SLOTS_DEF   = 8192;
    localparam int ROOT_CODES       = 256;
    localparam int OUT_CODE_W       = 12;
    localparam int OUT_DEPTH        = 4;

    typedef logic [OUT_CODE_W-1:0] out_code_t;

    // up to two results per input word, first one always in slot a
    typedef struct packed {
        logic      push_a;
        out_code_t code_a;
        logic      eos_a;
        logic      push_b;
        out_code_t code_b;
        logic      eos_b;
    } push_t;

endpackage

### rtl/lzwbc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwbc_ram
// Single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module lzwbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/lzwbc_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwbc_out_fifo
// Small result queue; takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
module lzwbc_out_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lzwbc_pkg::push_t      push,
    output logic                  room2,
    output logic                  out_valid,
    input  logic                  out_ready,
    output lzwbc_pkg::out_code_t  out_code,
    output logic                  out_eos,
    output logic [$clog2(lzwbc_pkg::OUT_DEPTH):0] count
);
    import lzwbc_pkg::*;

    localparam int PW = $clog2(OUT_DEPTH);

    out_code_t      code_mem [OUT_DEPTH];
    logic           eos_mem  [OUT_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PW:0]    count_reg, count_next;
    logic           pop;
    logic [PW-1:0]  wr_ptr_b;

    assign pop       = out_valid && out_ready;
    assign wr_ptr_b  = wr_ptr_reg + PW'(1);
    assign out_valid = (count_reg != '0);
    assign out_code  = code_mem[rd_ptr_reg];
    assign out_eos   = eos_mem[rd_ptr_reg];
    assign room2     = (count_reg <= (PW+1)'(OUT_DEPTH - 2));
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push.push_a) + PW'(push.push_b);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + (PW+1)'(push.push_a) + (PW+1)'(push.push_b)
                      - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push_a)
        begin
            code_mem[wr_ptr_reg] <= push.code_a;
            eos_mem[wr_ptr_reg]  <= push.eos_a;
        end
        if (push.push_b)
        begin
            code_mem[wr_ptr_b] <= push.code_b;
            eos_mem[wr_ptr_b]  <= push.eos_b;
        end
    end

endmodule

### rtl/lzw_byte_compressor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_byte_compressor_core
// LZW compressor: one byte in, fixed-width dictionary codes out.
// ----------------------------------------------------------------------------
// Lookup: a byte of an open phrase is looked up in the cycle after acceptance;
//   its results enter the output queue at the end of the final probe cycle.
// Input: bytes are taken only while idle, so the next byte waits until the last
//   one's probes of the single RAM port end, and while the queue lacks room for two.
// Reset (async, active low) and every stream end that added entries start a
//   clearing pass over all HASH_SLOTS slots (8192 by default), input held off.
// ----------------------------------------------------------------------------
module lzw_byte_compressor_core #(
    parameter int DICT_ENTRIES = lzwbc_pkg::DICT_ENTRIES_DEF,
    parameter int HASH_SLOTS   = lzwbc_pkg::HASH_SLOTS_DEF  // power of two
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [11:0] code, [15:12] zero
    output logic        m_axis_tlast    // end_of_stream
);
    import lzwbc_pkg::*;

    // code, key (prefix code + byte), hash index and slot widths
    localparam int CW = $clog2(DICT_ENTRIES);
    localparam int KW = CW + 8;
    localparam int HW = $clog2(HASH_SLOTS);
    localparam int PW = HW + 1;
    localparam int SW = 1 + KW + CW;
    localparam int FW = $clog2(OUT_DEPTH) + 1;

    localparam logic [HW-1:0] LAST_SLOT   = HW'(HASH_SLOTS - 1);
    localparam logic [PW-1:0] PROBE_LIMIT = PW'(HASH_SLOTS);
    localparam logic [CW:0]   FIRST_FREE  = (CW+1)'(ROOT_CODES);
    localparam logic [CW:0]   DICT_LIMIT  = (CW+1)'(DICT_ENTRIES);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic          active_reg, active_next;
    logic [CW:0]   free_reg, free_next;
    logic [7:0]    byte_reg, byte_next;
    logic          last_reg, last_next;
    logic [HW-1:0] idx_reg, idx_next;
    logic [PW-1:0] probe_reg, probe_next;
    logic [HW-1:0] clr_reg, clr_next;

    // table port
    logic          ram_en, ram_we;
    logic [HW-1:0] ram_addr;
    logic [SW-1:0] ram_wdata, ram_rdata;

    // output queue
    push_t         push;
    logic          room2;
    out_code_t     q_code;
    logic          q_eos;
    logic [FW-1:0] q_count;

    logic          accept;
    logic [KW-1:0] key_in, key_reg;
    logic          slot_valid;
    logic [KW-1:0] slot_key;
    logic [CW-1:0] slot_code;
    logic          hit, miss;
    logic [CW-1:0] cur_new;
    logic [CW:0]   free_new;

    assign s_axis_tready = (state_reg == ST_IDLE) && room2;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign key_in        = {cur_reg, s_axis_tdata};
    assign key_reg       = {cur_reg, byte_reg};

    // slot layout: {valid, key, code}
    assign slot_valid = ram_rdata[SW-1];
    assign slot_key   = ram_rdata[SW-2 -: KW];
    assign slot_code  = ram_rdata[CW-1:0];

    // probe outcome: hit, empty slot, or probe budget used up
    assign hit  = slot_valid && (slot_key == key_reg);
    assign miss = !hit && (!slot_valid || (probe_reg == PROBE_LIMIT));

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        active_next = active_reg;
        free_next   = free_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        idx_next    = idx_reg;
        probe_next  = probe_reg;
        clr_next    = clr_reg;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = idx_reg;
        ram_wdata   = '0;
        push        = '0;
        cur_new     = cur_reg;
        free_new    = free_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = clr_reg;
                clr_next = clr_reg + HW'(1);
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!active_reg)
                    begin
                        // first byte of a stream: no lookup
                        cur_next    = CW'(s_axis_tdata);
                        active_next = 1'b1;
                        if (s_axis_tlast)
                        begin
                            push.push_a = 1'b1;
                            push.code_a = OUT_CODE_W'(s_axis_tdata);
                            push.eos_a  = 1'b1;
                            cur_next    = '0;
                            active_next = 1'b0;
                        end
                    end
                    else
                    begin
                        ram_en     = 1'b1;
                        ram_addr   = key_in[HW-1:0];
                        idx_next   = key_in[HW-1:0];
                        byte_next  = s_axis_tdata;
                        last_next  = s_axis_tlast;
                        probe_next = PW'(1);
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_CHECK:
            begin
                if (hit || miss)
                begin
                    if (hit)
                    begin
                        cur_new = slot_code;
                    end
                    else
                    begin
                        push.push_a = 1'b1;
                        push.code_a = OUT_CODE_W'(cur_reg);
                        push.eos_a  = 1'b0;
                        if ((free_reg < DICT_LIMIT) && !slot_valid)
                        begin
                            ram_en    = 1'b1;
                            ram_we    = 1'b1;
                            ram_wdata = {1'b1, key_reg, free_reg[CW-1:0]};
                            free_new  = free_reg + (CW+1)'(1);
                        end
                        cur_new = CW'(byte_reg);
                    end
                    cur_next   = cur_new;
                    free_next  = free_new;
                    state_next = ST_IDLE;
                    if (last_reg)
                    begin
                        // flush; second result goes in slot b after a miss
                        if (hit)
                        begin
                            push.push_a = 1'b1;
                            push.code_a = OUT_CODE_W'(cur_new);
                            push.eos_a  = 1'b1;
                        end
                        else
                        begin
                            push.push_b = 1'b1;
                            push.code_b = OUT_CODE_W'(cur_new);
                            push.eos_b  = 1'b1;
                        end
                        cur_next    = '0;
                        active_next = 1'b0;
                        free_next   = FIRST_FREE;
                        if (free_new != FIRST_FREE)
                        begin
                            state_next = ST_CLEAR;
                        end
                    end
                end
                else
                begin
                    // occupied by another key: next slot
                    ram_en     = 1'b1;
                    ram_addr   = idx_reg + HW'(1);
                    idx_next   = idx_reg + HW'(1);
                    probe_next = probe_reg + PW'(1);
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            cur_reg    <= '0;
            active_reg <= 1'b0;
            free_reg   <= FIRST_FREE;
            clr_reg    <= '0;
            probe_reg  <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cur_reg    <= cur_next;
            active_reg <= active_next;
            free_reg   <= free_next;
            clr_reg    <= clr_next;
            probe_reg  <= probe_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        idx_reg  <= idx_next;
    end

    lzwbc_ram #(
        .WIDTH (SW),
        .DEPTH (HASH_SLOTS)
    ) u_table (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    lzwbc_out_fifo u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room2     (room2),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_code  (q_code),
        .out_eos   (q_eos),
        .count     (q_count)
    );

    assign m_axis_tdata = {4'b0000, q_code};
    assign m_axis_tlast = q_eos;

`ifndef NO_ASSERTIONS
    // a lookup always follows an accepted byte of an open phrase
    a_lookup_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && active_reg) |=> (state_reg == ST_CHECK))
        else $error("lookup not started after accepted byte");

    // the result queue never overflows
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= FW'(OUT_DEPTH))
        else $error("result queue overflow");

    // next free code never runs past the dictionary size
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= DICT_LIMIT)
        else $error("next free code out of range");

    // a stream end returns the dictionary to its roots
    a_stream_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && (hit || miss) && last_reg)
            |=> (!active_reg && free_reg == FIRST_FREE))
        else $error("stream end did not reset dictionary state");
`endif

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LZW byte compressor; both sides stall at random.
// Streams of bytes are driven on the input side, with directed cases first and
// then random streams. A small-alphabet mix forces dictionary hits, and one
// long random stream grows the dictionary. Every code word out is compared with a
// behavioral LZW encoder kept alongside, or with a directed row's expectation.
// ----------------------------------------------------------------------------
module tb;
    import lzwbc_pkg::*;

    localparam int DICT_MAX   = DICT_ENTRIES_DEF;
    localparam int LIMIT      = 4000000;
    localparam int RAND_ITEMS = 760;
    localparam int LONG_LEN   = 400;

    typedef struct packed {
        out_code_t code;
        logic      eos;
    } code_word_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       typed;   // expectations below replace the encoder's
        int         n_exp;
        code_word_t exp0;
        code_word_t exp1;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    // encoder state: (prefix code, byte) -> code
    int unsigned phrase_dict [int unsigned];
    int unsigned cur_code;
    bit          in_phrase;
    int unsigned free_code;

    code_word_t  pending_codes [$];
    int          errors;
    int          sent;
    bit          tx_stall;
    bit          rx_stall;
    longint      cycles;

    lzw_byte_compressor_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic clear_dict();
        phrase_dict.delete();
        cur_code  = 0;
        in_phrase = 1'b0;
        free_code = ROOT_CODES;
    endtask

    // Advance the encoder by one byte; returns the code words it emits.
    task automatic lzw_encode(input logic [7:0] b, input logic last,
                              output int n, output code_word_t w0,
                              output code_word_t w1);
        int unsigned key;
        code_word_t  w [2];
        n = 0;
        w[0] = '0;
        w[1] = '0;
        if (!in_phrase)
        begin
            cur_code  = {24'd0, b};
            in_phrase = 1'b1;
        end
        else
        begin
            key = (cur_code << 8) | {24'd0, b};
            if (phrase_dict.exists(key))
                cur_code = phrase_dict[key];
            else
            begin
                w[n] = '{code: cur_code[11:0], eos: 1'b0};
                n++;
                if (free_code < DICT_MAX)
                begin
                    phrase_dict[key] = free_code;
                    free_code++;
                end
                cur_code = {24'd0, b};
            end
        end
        if (last)
        begin
            w[n] = '{code: cur_code[11:0], eos: 1'b1};
            n++;
            clear_dict();
        end
        w0 = w[0];
        w1 = w[1];
    endtask

    // Drive one byte, wait for its acceptance, then queue its expected codes.
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input bit typed = 0, input int n_t = 0,
                             input code_word_t t0 = '0, input code_word_t t1 = '0);
        int         gap;
        int         n;
        code_word_t w0;
        code_word_t w1;
        gap = tx_stall ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        lzw_encode(b, last, n, w0, w1);
        if (typed)
        begin
            n  = n_t;
            w0 = t0;
            w1 = t1;
        end
        if (n > 0) pending_codes = {pending_codes, w0};
        if (n > 1) pending_codes = {pending_codes, w1};
        sent++;
    endtask

    task automatic send_stream(input int len, input int alpha);
        int         i;
        logic [7:0] base;
        logic [7:0] b;
        base = 8'($urandom_range(0, 255));
        for (i = 0; i < len; i++)
        begin
            if (alpha == 0)
                b = 8'($urandom_range(0, 255));
            else
                b = base + 8'($urandom_range(0, alpha - 1));
            // occasional early end breaks a stream short
            send_byte(b, (i == len - 1) || ($urandom_range(0, 99) == 0));
        end
    endtask

    task automatic wait_drained();
        while (pending_codes.size() != 0) @(posedge clk);
    endtask

    // directed rows
    stim_row_t rows [$];

    function automatic stim_row_t row(input logic [7:0] b, input logic last,
                                      input logic typed = 0, input int n = 0,
                                      input code_word_t e0 = '0,
                                      input code_word_t e1 = '0);
        row = '{data: b, last: last, typed: typed, n_exp: n, exp0: e0, exp1: e1};
    endfunction

    // stimulus
    initial
    begin
        int i;
        int len;
        int alpha;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        errors        = 0;
        sent          = 0;
        tx_stall      = 1'b1;
        clear_dict();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // single-byte streams at both byte extremes
        rows = {rows, row(8'h00, 1'b1, 1, 1, '{12'd0, 1'b1})};
        rows = {rows, row(8'hFF, 1'b1, 1, 1, '{12'd255, 1'b1})};
        // first byte gives nothing, miss, hit on code 256, miss with last
        rows = {rows, row(8'h41, 1'b0, 1, 0)};
        rows = {rows, row(8'h41, 1'b0, 1, 1, '{12'd65, 1'b0})};
        rows = {rows, row(8'h41, 1'b0, 1, 0)};
        rows = {rows, row(8'h41, 1'b1, 1, 2, '{12'd256, 1'b0}, '{12'd65, 1'b1})};
        // alternating extremes, then a repeat-heavy pattern
        rows = {rows, row(8'hFF, 1'b0)};
        rows = {rows, row(8'h00, 1'b0)};
        rows = {rows, row(8'hFF, 1'b0)};
        rows = {rows, row(8'h00, 1'b0)};
        rows = {rows, row(8'hFF, 1'b0)};
        rows = {rows, row(8'h00, 1'b0)};
        rows = {rows, row(8'hFF, 1'b1)};
        rows = {rows, row(8'h80, 1'b0)};
        rows = {rows, row(8'h7F, 1'b0)};
        rows = {rows, row(8'h80, 1'b0)};
        rows = {rows, row(8'h7F, 1'b0)};
        rows = {rows, row(8'h80, 1'b0)};
        rows = {rows, row(8'h7F, 1'b0)};
        rows = {rows, row(8'h80, 1'b0)};
        rows = {rows, row(8'h01, 1'b1)};
        foreach (rows[k])
            send_byte(rows[k].data, rows[k].last, rows[k].typed, rows[k].n_exp,
                      rows[k].exp0, rows[k].exp1);

        // random streams, mostly small alphabets so phrases grow
        while (sent < RAND_ITEMS)
        begin
            tx_stall = ($urandom_range(0, 3) != 0);
            len      = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                                   : $urandom_range(4, 60);
            case ($urandom_range(0, 3))
                0:       alpha = 0;
                1:       alpha = 1;
                default: alpha = $urandom_range(2, 6);
            endcase
            send_stream(len, alpha);
        end

        // hold off until everything is out, then one long burst stream and a short one
        s_axis_tvalid <= 1'b0;
        wait_drained();
        tx_stall = 1'b0;
        for (i = 0; i < LONG_LEN; i++)
            send_byte(8'($urandom_range(0, 255)), i == LONG_LEN - 1);
        tx_stall = 1'b1;
        send_stream(40, 3);
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // output side: random stalls, compare each word with the oldest expectation
    initial
    begin
        int         gap;
        code_word_t want;
        m_axis_tready = 1'b0;
        rx_stall      = 1'b1;
        forever
        begin
            if ($urandom_range(0, 63) == 0) rx_stall = ~rx_stall;
            gap = rx_stall ? $urandom_range(0, 7) : 0;
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && rst_n));
            if (pending_codes.size() == 0)
            begin
                $error("unexpected word: code %0d eos %0b", m_axis_tdata[11:0],
                       m_axis_tlast);
                errors++;
            end
            else
            begin
                want = pending_codes.pop_front();
                if (m_axis_tdata[11:0] !== want.code)
                begin
                    $error("code: expected %0d, got %0d", want.code, m_axis_tdata[11:0]);
                    errors++;
                end
                if (m_axis_tdata[15:12] !== 4'h0)
                begin
                    $error("pad: expected 0, got %0h", m_axis_tdata[15:12]);
                    errors++;
                end
                if (m_axis_tlast !== want.eos)
                begin
                    $error("end_of_stream: expected %0b, got %0b", want.eos, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule

### sim.f
rtl/lzwbc_pkg.sv
rtl/lzwbc_ram.sv
rtl/lzwbc_out_fifo.sv
rtl/lzw_byte_compressor_core.sv
sim/tb.sv
